// ===== rtl/core/time_table_linear_interpolator_assert.svh =====
// Assertion macros used by the interpolator back end (ttli_back).
// Each macro is sampled on the rising edge of clk and is switched off while rst_n is low.
`ifndef TIME_TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define TIME_TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTLI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttli check failed");

// The consequent must hold in the cycle after the antecedent.
`define TTLI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttli check failed");

`endif

// ===== rtl/core/ttli_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ttli_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;

    localparam int TIME_W     = 32;
    localparam int ACC_W      = 24;
    localparam int LOAD_W     = 38;
    localparam int IDX_W      = 10;
    localparam int AXIS_W     = 2;
    localparam int CNT_W      = 11;
    localparam int MASK_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // Signed 24-bit sample times an unsigned 32-bit distance.
    localparam int PROD_W = ACC_W + TIME_W + 1;
    localparam int NUM_W  = PROD_W + 1;
    // The magnitude scaled by 9800 needs 14 more bits.
    localparam int DIVD_W = NUM_W + 14;
    localparam int STEP_W = 7;

    // g in mm/s^2 is 9.8 * 1000 = 9800 = 2^13 + 2^10 + 2^9 + 2^6 + 2^3.
    localparam int G_SCALE     = 9800;
    localparam int SCALE_TERMS = 5;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MASK    = 1'b1;

    typedef struct packed {
        logic                     is_query;
        logic                     skip;
        logic                     wr_ok;
        logic [IDX_W-1:0]         idx;
        logic [TIME_W-1:0]        t;
        logic signed [ACC_W-1:0]  ax;
        logic signed [ACC_W-1:0]  ay;
        logic signed [ACC_W-1:0]  az;
        logic [AXIS_W-1:0]        axis;
    } ttli_cmd_t;

    function automatic logic [4:0] g_shift(input logic [STEP_W-1:0] k);
        logic [4:0] s;
        case (k)
            7'd0:    s = 5'd13;
            7'd1:    s = 5'd10;
            7'd2:    s = 5'd9;
            7'd3:    s = 5'd6;
            default: s = 5'd3;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ttli_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ttli_front #(
    parameter int MAX_SAMPLES = ttli_pkg::MAX_SAMPLES_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire                          action,
    input  wire [ttli_pkg::IDX_W-1:0]    sample_index,
    input  wire [ttli_pkg::TIME_W-1:0]   time_value,
    input  wire [ttli_pkg::ACC_W-1:0]    accel_x,
    input  wire [ttli_pkg::ACC_W-1:0]    accel_y,
    input  wire [ttli_pkg::ACC_W-1:0]    accel_z,
    input  wire [ttli_pkg::AXIS_W-1:0]   axis,
    input  wire [ttli_pkg::MASK_W-1:0]   axis_mask,
    output logic                         cmd_valid,
    input  wire                          cmd_ready,
    output ttli_pkg::ttli_cmd_t          cmd
);
    import ttli_pkg::*;

    ttli_cmd_t   ent_reg [2];
    logic        wp_reg, wp_next;
    logic        rp_reg, rp_next;
    logic [1:0]  cnt_reg, cnt_next;
    ttli_cmd_t   in_cmd;
    logic        push;
    logic        pop;
    logic        present;

    // An axis is present only for codes x, y, z with its mask bit set.
    always_comb
    begin
        case (axis)
            AXIS_X:  present = axis_mask[0];
            AXIS_Y:  present = axis_mask[1];
            AXIS_Z:  present = axis_mask[2];
            default: present = 1'b0;
        endcase
    end

    always_comb
    begin
        in_cmd.is_query = (action == ACT_QUERY);
        in_cmd.skip     = !present;
        in_cmd.wr_ok    = (32'(sample_index) < 32'(MAX_SAMPLES));
        in_cmd.idx      = sample_index;
        in_cmd.t        = time_value;
        in_cmd.ax       = accel_x;
        in_cmd.ay       = accel_y;
        in_cmd.az       = accel_z;
        in_cmd.axis     = axis;
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = ent_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wp_next  = push ? !wp_reg : wp_reg;
        rp_next  = pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wp_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/ttli_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "time_table_linear_interpolator_assert.svh"
module ttli_back #(
    parameter int MAX_SAMPLES = ttli_pkg::MAX_SAMPLES_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cmd_valid,
    output logic                              cmd_ready,
    input  ttli_pkg::ttli_cmd_t               cmd,
    input  wire [ttli_pkg::CNT_W-1:0]         sample_count,
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic signed [ttli_pkg::LOAD_W-1:0] load_value,
    output logic                              inside_span
);
    import ttli_pkg::*;

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_MUL1  = 3'd2;
    localparam logic [2:0] ST_MUL2  = 3'd3;
    localparam logic [2:0] ST_ABS   = 3'd4;
    localparam logic [2:0] ST_SCALE = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [TIME_W-1:0]          time_mem [MAX_SAMPLES];
    logic [3*ACC_W-1:0]         acc_mem  [MAX_SAMPLES];
    logic [TIME_W-1:0]          time_q;
    logic [3*ACC_W-1:0]         acc_q;

    logic [2:0]                 state_reg, state_next;
    logic [CW-1:0]              addr_reg, addr_next;
    logic                       rd_vld_reg, rd_vld_next;
    logic                       rd_en;
    logic                       wr_en;
    logic [TIME_W-1:0]          t_reg, t_next;
    logic [AXIS_W-1:0]          axis_reg, axis_next;
    logic [TIME_W-1:0]          prev_t_reg, prev_t_next;
    logic signed [ACC_W-1:0]    prev_a_reg, prev_a_next;
    logic signed [ACC_W-1:0]    nxt_a_reg, nxt_a_next;
    logic [TIME_W-1:0]          d1_reg, d1_next;
    logic [TIME_W-1:0]          d2_reg, d2_next;
    logic [TIME_W-1:0]          div_w_reg, div_w_next;
    logic signed [PROD_W-1:0]   p1_reg, p1_next;
    logic signed [NUM_W-1:0]    num_reg, num_next;
    logic                       neg_reg, neg_next;
    logic [NUM_W-1:0]           mag_reg, mag_next;
    logic [DIVD_W-1:0]          div_d_reg, div_d_next;
    logic [TIME_W:0]            div_rem_reg, div_rem_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic                       res_inside_reg, res_inside_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [LOAD_W-1:0]   load_reg, load_next;
    logic                       inside_reg, inside_next;

    logic [CW-1:0]              count_c;
    logic signed [ACC_W-1:0]    acc_sel;
    logic                       hit;
    logic                       more;
    logic [TIME_W:0]            rem_sh;
    logic                       ge;
    logic [LOAD_W-1:0]          quo;

    assign count_c = (32'(sample_count) > 32'(MAX_SAMPLES)) ? CW'(MAX_SAMPLES)
                                                             : CW'(sample_count);

    always_comb
    begin
        case (axis_reg)
            AXIS_X:  acc_sel = acc_q[ACC_W-1:0];
            AXIS_Y:  acc_sel = acc_q[2*ACC_W-1:ACC_W];
            default: acc_sel = acc_q[3*ACC_W-1:2*ACC_W];
        endcase
    end

    assign hit       = rd_vld_reg && (t_reg <= time_q);
    assign more      = (addr_reg < count_c);
    assign rem_sh    = {div_rem_reg[TIME_W-1:0], div_d_reg[DIVD_W-1]};
    assign ge        = (rem_sh >= {1'b0, div_w_reg});
    assign quo       = div_d_reg[LOAD_W-1:0];
    assign cmd_ready = (state_reg == ST_IDLE);
    assign wr_en     = cmd_valid && cmd_ready && !cmd.is_query && cmd.wr_ok;

    assign out_valid   = out_valid_reg;
    assign load_value  = load_reg;
    assign inside_span = inside_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            time_mem[AW'(cmd.idx)] <= cmd.t;
            acc_mem[AW'(cmd.idx)]  <= {cmd.az, cmd.ay, cmd.ax};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            time_q <= time_mem[addr_reg[AW-1:0]];
            acc_q  <= acc_mem[addr_reg[AW-1:0]];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        rd_vld_next     = rd_vld_reg;
        rd_en           = 1'b0;
        t_next          = t_reg;
        axis_next       = axis_reg;
        prev_t_next     = prev_t_reg;
        prev_a_next     = prev_a_reg;
        nxt_a_next      = nxt_a_reg;
        d1_next         = d1_reg;
        d2_next         = d2_reg;
        div_w_next      = div_w_reg;
        p1_next         = p1_reg;
        num_next        = num_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        div_d_next      = div_d_reg;
        div_rem_next    = div_rem_reg;
        step_next       = step_reg;
        res_inside_next = res_inside_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        load_next       = load_reg;
        inside_next     = inside_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && cmd.is_query)
                begin
                    t_next      = cmd.t;
                    axis_next   = cmd.axis;
                    prev_t_next = '0;
                    prev_a_next = '0;
                    addr_next   = '0;
                    rd_vld_next = 1'b0;
                    if (cmd.skip)
                    begin
                        res_inside_next = 1'b0;
                        state_next      = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    nxt_a_next  = acc_sel;
                    rd_vld_next = 1'b0;
                    if (time_q <= prev_t_reg)
                    begin
                        d1_next    = '0;
                        d2_next    = TIME_W'(1);
                        div_w_next = TIME_W'(1);
                    end
                    else
                    begin
                        d1_next    = time_q - t_reg;
                        d2_next    = t_reg - prev_t_reg;
                        div_w_next = time_q - prev_t_reg;
                    end
                    state_next = ST_MUL1;
                end
                else
                begin
                    if (rd_vld_reg)
                    begin
                        prev_t_next = time_q;
                        prev_a_next = acc_sel;
                    end
                    if (more)
                    begin
                        rd_en       = 1'b1;
                        addr_next   = addr_reg + CW'(1);
                        rd_vld_next = 1'b1;
                    end
                    else if (rd_vld_reg)
                    begin
                        rd_vld_next = 1'b0;
                    end
                    else
                    begin
                        res_inside_next = 1'b0;
                        state_next      = ST_OUT;
                    end
                end
            end
            ST_MUL1:
            begin
                p1_next    = prev_a_reg * $signed({1'b0, d1_reg});
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                num_next   = $signed({p1_reg[PROD_W-1], p1_reg})
                           + (nxt_a_reg * $signed({1'b0, d2_reg}));
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                neg_next   = num_reg[NUM_W-1];
                mag_next   = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
                div_d_next = '0;
                step_next  = '0;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                div_d_next = div_d_reg + (DIVD_W'(mag_reg) << g_shift(step_reg));
                if (step_reg == STEP_W'(SCALE_TERMS - 1))
                begin
                    step_next    = '0;
                    div_rem_next = '0;
                    state_next   = ST_DIV;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_DIV:
            begin
                div_rem_next = ge ? (rem_sh - {1'b0, div_w_reg}) : rem_sh;
                div_d_next   = {div_d_reg[DIVD_W-2:0], ge};
                if (step_reg == STEP_W'(DIVD_W - 1))
                begin
                    res_inside_next = 1'b1;
                    state_next      = ST_OUT;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    inside_next    = res_inside_reg;
                    if (res_inside_reg)
                    begin
                        load_next = neg_reg ? $signed(-quo) : $signed(quo);
                    end
                    else
                    begin
                        load_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            addr_reg       <= '0;
            rd_vld_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            step_reg       <= '0;
            res_inside_reg <= 1'b0;
            div_rem_reg    <= '0;
            div_w_reg      <= TIME_W'(1);
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            rd_vld_reg     <= rd_vld_next;
            out_valid_reg  <= out_valid_next;
            step_reg       <= step_next;
            res_inside_reg <= res_inside_next;
            div_rem_reg    <= div_rem_next;
            div_w_reg      <= div_w_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        axis_reg   <= axis_next;
        prev_t_reg <= prev_t_next;
        prev_a_reg <= prev_a_next;
        nxt_a_reg  <= nxt_a_next;
        d1_reg     <= d1_next;
        d2_reg     <= d2_next;
        p1_reg     <= p1_next;
        num_reg    <= num_next;
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        div_d_reg  <= div_d_next;
        load_reg   <= load_next;
        inside_reg <= inside_next;
    end

    // Read data under comparison always belongs to an entry already issued.
    `TTLI_ASSERT_NOW(a_scan_data_issued, (state_reg == ST_SCAN) && rd_vld_reg, addr_reg != '0)
    // The scan never reads past the clipped sample count.
    `TTLI_ASSERT_NOW(a_scan_in_range, state_reg == ST_SCAN, addr_reg <= count_c)
    // The partial remainder stays below the divisor during the divide.
    `TTLI_ASSERT_NOW(a_div_rem_bound, state_reg == ST_DIV, div_rem_reg < {1'b0, div_w_reg})
    // A finished divide always hands a result to the output stage.
    `TTLI_ASSERT_NEXT(a_div_to_out,
        (state_reg == ST_DIV) && (step_reg == STEP_W'(DIVD_W - 1)),
        (state_reg == ST_OUT) && res_inside_reg)

endmodule
`default_nettype wire

// ===== rtl/core/time_table_linear_interpolator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   action, sample_index, time_value,
//                                            accel_x, accel_y, accel_z, axis
// out       output     out_valid / out_ready load_value, inside_span
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A sample write is stored in the tables when the back end takes it from the head of the queue.
// A query scans the entries in order up to the first time at or after the query time; the
// single read port of the tables sets the scan at one entry per cycle, and a bit-serial
// divider follows the multiplies and the scaling.
// A query for an absent axis skips the scan and goes straight to the output stage.
// Reset (rst_n low, asynchronous) clears the queue, the control state and both registers;
// the tables keep no reset and need no clearing pass.
// A two-entry queue lets the input side take up to two transfers while the back end works or
// while a finished result waits on out_ready.
module time_table_linear_interpolator #(
    parameter int MAX_SAMPLES = ttli_pkg::MAX_SAMPLES_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire                                action,
    input  wire [ttli_pkg::IDX_W-1:0]          sample_index,
    input  wire [ttli_pkg::TIME_W-1:0]         time_value,
    input  wire [ttli_pkg::ACC_W-1:0]          accel_x,
    input  wire [ttli_pkg::ACC_W-1:0]          accel_y,
    input  wire [ttli_pkg::ACC_W-1:0]          accel_z,
    input  wire [ttli_pkg::AXIS_W-1:0]         axis,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic signed [ttli_pkg::LOAD_W-1:0] load_value,
    output logic                               inside_span,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [ttli_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [ttli_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ttli_pkg::*;

    logic [CNT_W-1:0]  sample_count_reg;
    logic [MASK_W-1:0] axis_mask_reg;
    ttli_cmd_t         cmd;
    logic              cmd_valid;
    logic              cmd_ready;

    // Configuration is always taken; the user writes it only while the block is idle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= '0;
            axis_mask_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SAMPLE_COUNT: sample_count_reg <= cfg_data;
                CFG_AXIS_MASK:    axis_mask_reg    <= cfg_data[MASK_W-1:0];
                default:          ;
            endcase
        end
    end

    // The front end classifies each transfer (write or query, present axis, index in range)
    // and queues it for the back end.
    ttli_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .sample_index (sample_index),
        .time_value   (time_value),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .axis         (axis),
        .axis_mask    (axis_mask_reg),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd)
    );

    // The back end owns the tables, scans for the bracketing samples, forms the weighted
    // sum with two multiplies, scales by 9800 with shifts and adds, and divides bit-serially.
    ttli_back #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .sample_count (sample_count_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .load_value   (load_value),
        .inside_span  (inside_span)
    );

endmodule
`default_nettype wire

// ===== sim/time_table_linear_interpolator_tb.sv =====
`timescale 1ns / 1ps
module time_table_linear_interpolator_tb;
    import ttli_pkg::*;

    // One input transfer as the sender holds it in its pending queue.
    typedef struct {
        logic                    action;
        logic [IDX_W-1:0]        idx;
        logic [TIME_W-1:0]       t;
        logic signed [ACC_W-1:0] ax;
        logic signed [ACC_W-1:0] ay;
        logic signed [ACC_W-1:0] az;
        logic [AXIS_W-1:0]       axis;
    } sample_cmd_t;

    // One expected result of a query.
    typedef struct {
        logic signed [LOAD_W-1:0] load;
        logic                     in_span;
    } load_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     action = ACT_WRITE;
    logic [IDX_W-1:0]         sample_index = '0;
    logic [TIME_W-1:0]        time_value = '0;
    logic [ACC_W-1:0]         accel_x = '0;
    logic [ACC_W-1:0]         accel_y = '0;
    logic [ACC_W-1:0]         accel_z = '0;
    logic [AXIS_W-1:0]        axis = AXIS_X;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [LOAD_W-1:0] load_value;
    logic                     inside_span;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = CFG_SAMPLE_COUNT;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    time_table_linear_interpolator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .sample_index (sample_index),
        .time_value   (time_value),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .axis         (axis),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .load_value   (load_value),
        .inside_span  (inside_span),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // The sender's pending transfers and the results the queries are expected to give.
    sample_cmd_t  cmd_q[$];
    load_result_t load_expect_q[$];
    int unsigned  n_enqueued = 0;
    int unsigned  n_accepted = 0;
    int unsigned  n_errors = 0;
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_idle_pct = 0;
    logic         in_taken = 1'b0;

    // The predictor's own copy of the tables and the two registers.
    logic [TIME_W-1:0]       tbl_time [MAX_SAMPLES_DEF];
    logic signed [ACC_W-1:0] tbl_acc [MAX_SAMPLES_DEF][3];
    logic [CNT_W-1:0]        count_cfg = '0;
    logic [MASK_W-1:0]       mask_cfg = '0;

    // The stimulus side keeps the times it has written so that queries land near them.
    logic [TIME_W-1:0] gen_time [MAX_SAMPLES_DEF];

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        n_errors++;
    endtask

    // Interpolated load for a query time and axis, from the current table contents.
    function automatic load_result_t predict_load(input logic [TIME_W-1:0] t,
                                                  input logic [AXIS_W-1:0] ax);
        load_result_t      res;
        int                cnt;
        int                nxt;
        longint            pa;
        longint            na;
        longint            num;
        longint unsigned   w;
        longint unsigned   mag;
        longint unsigned   val;
        logic [TIME_W-1:0] pt;
        logic [TIME_W-1:0] nt;
        res.load = '0;
        res.in_span = 1'b0;
        if (ax > AXIS_Z || !mask_cfg[ax])
            return res;
        cnt = (count_cfg > MAX_SAMPLES_DEF) ? MAX_SAMPLES_DEF : int'(count_cfg);
        nxt = -1;
        for (int i = 0; i < cnt; i++)
        begin
            if (t <= tbl_time[i])
            begin
                nxt = i;
                break;
            end
        end
        if (nxt < 0)
            return res;
        na = tbl_acc[nxt][ax];
        nt = tbl_time[nxt];
        pa = (nxt == 0) ? 0 : tbl_acc[nxt - 1][ax];
        pt = (nxt == 0) ? '0 : tbl_time[nxt - 1];
        res.in_span = 1'b1;
        if (nt <= pt)
        begin
            // A zero-width interval takes the load of the next sample.
            num = na * G_SCALE;
            res.load = num[LOAD_W-1:0];
            return res;
        end
        w = longint'({32'd0, nt}) - longint'({32'd0, pt});
        num = pa * longint'({32'd0, nt} - {32'd0, t}) + na * longint'({32'd0, t} - {32'd0, pt});
        mag = (num < 0) ? longint'(-num) : longint'(num);
        // Scale the quotient and the remainder apart so that truncation matches.
        val = (mag / w) * G_SCALE + ((mag % w) * G_SCALE) / w;
        if (num < 0)
            val = -val;
        res.load = val[LOAD_W-1:0];
        return res;
    endfunction

    // Sender: a new transfer is offered only once the previous one has gone.
    always @(negedge clk)
    begin
        sample_cmd_t c;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                c = cmd_q.pop_front();
                in_valid     <= 1'b1;
                action       <= c.action;
                sample_index <= c.idx;
                time_value   <= c.t;
                accel_x      <= c.ax;
                accel_y      <= c.ay;
                accel_z      <= c.az;
                axis         <= c.axis;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: stalls at random.
    always @(negedge clk)
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    // Input transfers update the predictor; output transfers are checked in order.
    always @(posedge clk)
    begin
        load_result_t got;
        load_result_t exp_r;
        in_taken <= in_valid && in_ready;
        if (in_valid && in_ready)
        begin
            n_accepted++;
            if (action == ACT_WRITE)
            begin
                tbl_time[sample_index]   = time_value;
                tbl_acc[sample_index][0] = accel_x;
                tbl_acc[sample_index][1] = accel_y;
                tbl_acc[sample_index][2] = accel_z;
            end
            else
                load_expect_q.insert(load_expect_q.size(), predict_load(time_value, axis));
        end
        if (out_valid && out_ready)
        begin
            got.load = load_value;
            got.in_span = inside_span;
            if (load_expect_q.size() == 0)
                report_mismatch("result transfer with no query waiting");
            else
            begin
                exp_r = load_expect_q.pop_front();
                if (got.load !== exp_r.load)
                    report_mismatch($sformatf("load_value %0d, expected %0d",
                                              got.load, exp_r.load));
                if (got.in_span !== exp_r.in_span)
                    report_mismatch($sformatf("inside_span %0b, expected %0b",
                                              got.in_span, exp_r.in_span));
            end
        end
    end

    task automatic push_cmd(input logic act, input logic [IDX_W-1:0] idx,
                            input logic [TIME_W-1:0] t, input logic [ACC_W-1:0] ax,
                            input logic [ACC_W-1:0] ay, input logic [ACC_W-1:0] az,
                            input logic [AXIS_W-1:0] q_axis);
        sample_cmd_t c;
        c.action = act;
        c.idx = idx;
        c.t = t;
        c.ax = ax;
        c.ay = ay;
        c.az = az;
        c.axis = q_axis;
        if (act == ACT_WRITE)
            gen_time[idx] = t;
        cmd_q.insert(cmd_q.size(), c);
        n_enqueued++;
    endtask

    // A query carries random junk in the fields it does not use.
    task automatic push_query(input logic [TIME_W-1:0] t, input logic [AXIS_W-1:0] q_axis);
        push_cmd(ACT_QUERY, IDX_W'($urandom), t, ACC_W'($urandom), ACC_W'($urandom),
                 ACC_W'($urandom), q_axis);
    endtask

    function automatic logic [ACC_W-1:0] rand_accel();
        case ($urandom_range(7))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return '0;
            default: return ACC_W'($urandom);
        endcase
    endfunction

    // Query times mostly hit sample times or fall between neighbors.
    function automatic logic [TIME_W-1:0] pick_query_time(input int n);
        int              k;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned top;
        if (n == 0)
            return $urandom_range(3) == 0 ? '0 : $urandom;
        k = $urandom_range(n - 1);
        case ($urandom_range(9))
            0, 1, 2, 3: return gen_time[k];
            4, 5, 6:
            begin
                lo = (k == 0) ? 0 : gen_time[k - 1];
                hi = gen_time[k];
                if (hi > lo)
                    return TIME_W'(lo + 1 + ({$urandom, $urandom} % (hi - lo)));
                return gen_time[k];
            end
            7: return '0;
            8:
            begin
                top = 0;
                for (int i = 0; i < n; i++)
                    if (gen_time[i] > top)
                        top = gen_time[i];
                return (top == 64'hFFFFFFFF) ? '1 : TIME_W'(top + 1 + $urandom_range(1000));
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [AXIS_W-1:0] rand_axis();
        return ($urandom_range(9) == 0) ? 2'd3 : AXIS_W'($urandom_range(2));
    endfunction

    // Waits until every pending transfer is taken and every result has come, then
    // lets the back end finish any trailing sample writes.
    task automatic drain_all();
        while (n_accepted != n_enqueued || load_expect_q.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_SAMPLE_COUNT)
            count_cfg = d;
        else
            mask_cfg = d[MASK_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // The mask register ignores its upper bits, so junk goes there.
    task automatic write_mask(input logic [MASK_W-1:0] m);
        write_reg(CFG_AXIS_MASK, (CFG_DATA_W'($urandom) & 11'h7F8) | m);
    endtask

    // Fills entries 0..n-1 with times that mostly rise, in steps of a chosen size.
    task automatic fill_table(input int n, input int step_mode);
        longint unsigned t;
        longint unsigned step;
        t = ($urandom_range(2) == 0) ? 0 : $urandom_range(step_mode == 0 ? 20 : 100000);
        for (int i = 0; i < n; i++)
        begin
            push_cmd(ACT_WRITE, IDX_W'(i), TIME_W'(t), rand_accel(), rand_accel(),
                     rand_accel(), AXIS_W'($urandom));
            case (step_mode)
                0: step = $urandom_range(50);
                1: step = $urandom_range(1, 100000);
                2: step = $urandom >> $urandom_range(4, 11);
                default: step = $urandom_range(1, 4000000);
            endcase
            t = t + step;
            if (t > 64'hFFFFFFFF)
                t = 64'hFFFFFFFF;
        end
    endtask

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int n;
        int cnt;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. With the reset mask every axis is absent.
        push_query(32'd1234, AXIS_X);
        drain_all();
        write_mask(3'b111);
        // An empty table.
        push_query(32'd0, AXIS_Y);
        // Time zero at entry 0 is a zero-width interval; entries 1 and 2 share a time;
        // the last entry sits at the top of the time range.
        push_cmd(ACT_WRITE, 10'd0, 32'd0, 24'h800000, 24'h7FFFFF, 24'h000001, AXIS_X);
        push_cmd(ACT_WRITE, 10'd1, 32'd100, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, AXIS_Y);
        push_cmd(ACT_WRITE, 10'd2, 32'd100, 24'h123456, 24'h000000, 24'h800000, AXIS_Z);
        push_cmd(ACT_WRITE, 10'd1023, 32'hFFFFFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 2'd3);
        push_cmd(ACT_WRITE, 10'd3, 32'hFFFFFFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 2'd3);
        drain_all();
        write_reg(CFG_SAMPLE_COUNT, 11'd4);
        push_query(32'd0, AXIS_X);
        push_query(32'd50, AXIS_X);
        push_query(32'd100, AXIS_Y);
        push_query(32'd101, AXIS_Z);
        push_query(32'hFFFFFFFF, AXIS_X);
        push_query(32'h80000000, AXIS_Y);
        push_query(32'd7, 2'd3);
        drain_all();
        // Past the span once only two samples count; then a masked-off axis.
        write_reg(CFG_SAMPLE_COUNT, 11'd2);
        push_query(32'd101, AXIS_X);
        push_query(32'd100, AXIS_Z);
        drain_all();
        write_mask(3'b101);
        push_query(32'd60, AXIS_Y);
        push_query(32'd60, AXIS_Z);
        drain_all();

        // Random part: blocks of fresh table contents under new register settings.
        for (int blk = 0; blk < 12; blk++)
        begin
            if (blk < 4)
            begin
                send_idle_pct = 10;
                recv_idle_pct = 73;
            end
            else if (blk < 8)
            begin
                send_idle_pct = 73;
                recv_idle_pct = 10;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(5))
                0: n = $urandom_range(2);
                default: n = $urandom_range(3, 40);
            endcase
            cnt = ($urandom_range(3) == 0) ? $urandom_range(n) : n;
            write_reg(CFG_SAMPLE_COUNT, CNT_W'(cnt));
            write_mask(($urandom_range(3) == 0) ? MASK_W'($urandom) : 3'b111);
            fill_table(n, $urandom_range(3));
            for (int k = 0; k < 45 - n; k++)
            begin
                if ($urandom_range(99) < 12)
                    // Rewrites land anywhere in the table, so times may fall out of order.
                    push_cmd(ACT_WRITE,
                             ($urandom_range(1) == 0 && n > 0) ? IDX_W'($urandom_range(n - 1))
                                                               : IDX_W'($urandom),
                             ($urandom_range(1) == 0) ? pick_query_time(n) : $urandom,
                             rand_accel(), rand_accel(), rand_accel(), AXIS_W'($urandom));
                else
                    push_query(pick_query_time(cnt), rand_axis());
            end
            drain_all();
        end

        // Full table: a count above the table size is clamped, then the exact size.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fill_table(MAX_SAMPLES_DEF, 3);
        drain_all();
        write_reg(CFG_SAMPLE_COUNT, 11'h7FF);
        write_mask(3'b111);
        for (int k = 0; k < 12; k++)
            push_query(pick_query_time(MAX_SAMPLES_DEF), rand_axis());
        push_query(32'hFFFFFFFF, AXIS_Z);
        drain_all();
        write_reg(CFG_SAMPLE_COUNT, 11'd1024);
        write_mask(3'b010);
        for (int k = 0; k < 8; k++)
            push_query(pick_query_time(MAX_SAMPLES_DEF), rand_axis());
        drain_all();

        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
